>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro checks a property on the rising edge of clk and is silent while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/lcp_pkg.sv
package lcp_pkg;

	// Timestamp and its saturation point.
	localparam int STAMP_W   = 6;
	localparam int STAMP_MAX = 63;
	typedef logic [STAMP_W-1:0] stamp_t;

	// Matrix entry codes.
	typedef logic signed [1:0] relation_t;
	localparam relation_t REL_P1_TO_P2 = 2'sb01;
	localparam relation_t REL_P2_TO_P1 = 2'sb11;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_P1_EVENTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_P2_EVENTS = 2'd1;

	// Result fields.
	localparam int EVENT_IDX_W = 4;

	// Command to one row of cells.
	typedef struct packed {
		logic   init;
		logic   bump;
		stamp_t cand;
	} row_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RIPPLE,
		ST_EMIT
	} state_t;

	// Increment with saturation.
	function automatic stamp_t sat_inc(input stamp_t s);
		return (s == stamp_t'(STAMP_MAX)) ? s : s + 1'b1;
	endfunction

endpackage

>>> rtl/core/lcp_in_if.sv
interface lcp_in_if;
	logic                      valid;
	logic                      ready;
	logic signed [1:0]         relation;

	modport source (output valid, output relation, input ready);
	modport sink   (input valid, input relation, output ready);
endinterface

>>> rtl/core/lcp_out_if.sv
interface lcp_out_if;
	logic       valid;
	logic       ready;
	logic       process_id;
	logic [3:0] event_index;
	logic [5:0] timestamp;
	logic       last_result;

	modport source (output valid, output process_id, output event_index, output timestamp,
		output last_result, input ready);
	modport sink   (input valid, input process_id, input event_index, input timestamp,
		input last_result, output ready);
endinterface

>>> rtl/core/lcp_cfg_if.sv
interface lcp_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [4:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/lcp_cell.sv
module lcp_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  lcp_pkg::stamp_t init_stamp,
	input  logic            init,
	input  logic            bump,
	input  lcp_pkg::stamp_t cand,
	input  lcp_pkg::stamp_t prev_stamp,
	input  logic            prev_pulse,
	input  logic            in_use,
	output lcp_pkg::stamp_t stamp,
	output logic            pulse
);
	import lcp_pkg::*;

	stamp_t stamp_q;
	logic   pulse_q;

	// A bump raises this stamp to the candidate; a pulse from the left
	// rewrites it to the neighbor's stamp plus one and moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q <= init_stamp;
			pulse_q <= 1'b0;
		end else if (init) begin
			stamp_q <= init_stamp;
			pulse_q <= 1'b0;
		end else if (bump) begin
			if (cand > stamp_q) begin
				stamp_q <= cand;
			end
			pulse_q <= 1'b1;
		end else if (prev_pulse && in_use) begin
			stamp_q <= sat_inc(prev_stamp);
			pulse_q <= 1'b1;
		end else begin
			pulse_q <= 1'b0;
		end
	end

	assign stamp = stamp_q;
	assign pulse = pulse_q;

endmodule

>>> rtl/core/lcp_row.sv
module lcp_row #(
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lcp_pkg::row_cmd_t                    cmd,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] pos,
	input  logic [$clog2(DEPTH + 1)-1:0]         count,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output lcp_pkg::stamp_t                      rd_stamp,
	output logic                                 busy
);
	import lcp_pkg::*;

	localparam int A_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int C_W = $clog2(DEPTH + 1);

	stamp_t             stamps [DEPTH];
	logic   [DEPTH-1:0] pulses;

	// One cell per event; each cell looks only at its left neighbor.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		localparam int INIT_V = (k + 1 > STAMP_MAX) ? STAMP_MAX : k + 1;
		stamp_t prev_stamp;
		logic   prev_pulse;

		if (k == 0) begin : g_head
			assign prev_stamp = '0;
			assign prev_pulse = 1'b0;
		end else begin : g_link
			assign prev_stamp = stamps[k-1];
			assign prev_pulse = pulses[k-1];
		end

		lcp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.init_stamp (stamp_t'(INIT_V)),
			.init       (cmd.init),
			.bump       (cmd.bump && (pos == A_W'(k))),
			.cand       (cmd.cand),
			.prev_stamp (prev_stamp),
			.prev_pulse (prev_pulse),
			.in_use     (C_W'(k) < count),
			.stamp      (stamps[k]),
			.pulse      (pulses[k])
		);
	end

	assign rd_stamp = stamps[rd_addr];
	assign busy     = |pulses;

endmodule

>>> rtl/core/lamport_clock_two_process.sv
// Lamport timestamps for two processes, computed from a message matrix.
// Channels: entry (sink) takes one matrix entry per item in row-major order,
// P1 events as rows and P2 events as columns; result (source) gives one
// timestamp per item; cfg (sink, always ready) writes p1_events (index 0) or
// p2_events (index 1). A write to either register restarts the run.
// Each entry is followed by a rewrite phase before the next one is taken. An
// entry with a message rewrites the later events of the receiving process: the
// rewrite travels one cell per cycle down the chain of stamp cells. Once the
// rewrite of the final entry of the matrix is done, one result item per event in
// use of each process follows, one per cycle while the receiver is ready, P1
// first; the last one carries last_result. No entry is taken during that output.
// Results pass through a single output register, so a stalled receiver only
// holds the output sequence; the next entry is accepted once the last result
// sits in that register.
// Reset gives p1_events = 5, p2_events = 3, every stamp equal to its event
// index plus one, and the matrix position at the first entry.
`include "assert_macros.svh"

module lamport_clock_two_process #(
	parameter int MAX_P1_EVENTS = 16,
	parameter int MAX_P2_EVENTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	lcp_in_if.sink        entry,
	lcp_out_if.source     result,
	lcp_cfg_if.sink       cfg
);
	import lcp_pkg::*;

	localparam int A1_W = (MAX_P1_EVENTS > 1) ? $clog2(MAX_P1_EVENTS) : 1;
	localparam int A2_W = (MAX_P2_EVENTS > 1) ? $clog2(MAX_P2_EVENTS) : 1;
	localparam int N1_W = $clog2(MAX_P1_EVENTS + 1);
	localparam int N2_W = $clog2(MAX_P2_EVENTS + 1);
	localparam int E_W  = (A1_W > A2_W) ? A1_W : A2_W;
	localparam int NW   = (N1_W > N2_W) ? N1_W : N2_W;

	state_t                state_q, state_d;
	logic [CFG_DATA_W-1:0] p1_events_q, p2_events_q;
	logic [A1_W-1:0]       row_pos_q;
	logic [A2_W-1:0]       col_pos_q;
	logic                  end_q;
	logic                  emit_pid_q;
	logic [E_W-1:0]        emit_idx_q;
	logic                  out_valid_q;
	logic                  out_pid_q;
	logic [EVENT_IDX_W-1:0] out_idx_q;
	stamp_t                out_stamp_q;
	logic                  out_last_q;

	logic [N1_W-1:0] n1;
	logic [N2_W-1:0] n2;
	logic [A1_W-1:0] r_cl, r_next;
	logic [A2_W-1:0] c_cl, c_next;
	logic [N1_W-1:0] r_inc;
	logic [N2_W-1:0] c_inc;
	logic            wrap, end_run;
	logic            acc, cfg_known, load, at_end, emit_done, restart, busy;
	logic [NW-1:0]   emit_n;
	row_cmd_t        cmd1, cmd2;
	stamp_t          rd1, rd2;
	logic            busy1, busy2;
	logic [A1_W-1:0] rd_addr1;
	logic [A2_W-1:0] rd_addr2;

	// Event counts in use: zero counts as one, large counts clamp to the row size.
	always_comb begin
		if (p1_events_q == '0) begin
			n1 = N1_W'(1);
		end else if (32'(p1_events_q) > MAX_P1_EVENTS) begin
			n1 = N1_W'(MAX_P1_EVENTS);
		end else begin
			n1 = N1_W'(p1_events_q);
		end
		if (p2_events_q == '0) begin
			n2 = N2_W'(1);
		end else if (32'(p2_events_q) > MAX_P2_EVENTS) begin
			n2 = N2_W'(MAX_P2_EVENTS);
		end else begin
			n2 = N2_W'(p2_events_q);
		end
	end

	// Matrix position and its successor.
	always_comb begin
		r_cl    = (N1_W'(row_pos_q) < n1) ? row_pos_q : A1_W'(n1 - 1'b1);
		c_cl    = (N2_W'(col_pos_q) < n2) ? col_pos_q : A2_W'(n2 - 1'b1);
		c_inc   = N2_W'(c_cl) + 1'b1;
		r_inc   = N1_W'(r_cl) + 1'b1;
		wrap    = (c_inc >= n2);
		end_run = wrap && (r_inc >= n1);
		c_next  = wrap ? '0 : A2_W'(c_inc);
		r_next  = wrap ? A1_W'(r_inc) : r_cl;
		if (end_run) begin
			c_next = '0;
			r_next = '0;
		end
	end

	assign acc       = entry.valid && entry.ready;
	assign cfg_known = cfg.valid && cfg.ready &&
		((cfg.index == REG_P1_EVENTS) || (cfg.index == REG_P2_EVENTS));
	assign busy      = busy1 || busy2;

	// Output sequencing over all P1 stamps, then all P2 stamps.
	assign load      = (state_q == ST_EMIT) && (!out_valid_q || result.ready);
	assign emit_n    = emit_pid_q ? NW'(n2) : NW'(n1);
	assign at_end    = (NW'(emit_idx_q) + 1'b1 == emit_n);
	assign emit_done = load && at_end && emit_pid_q;
	assign restart   = cfg_known || emit_done;

	// Row commands: a bump goes to the receiving process at its position.
	always_comb begin
		rd_addr1   = (state_q == ST_EMIT) ? A1_W'(emit_idx_q) : r_cl;
		rd_addr2   = (state_q == ST_EMIT) ? A2_W'(emit_idx_q) : c_cl;
		cmd1.init  = restart;
		cmd1.bump  = acc && (entry.relation == REL_P2_TO_P1);
		cmd1.cand  = sat_inc(rd2);
		cmd2.init  = restart;
		cmd2.bump  = acc && (entry.relation == REL_P1_TO_P2);
		cmd2.cand  = sat_inc(rd1);
	end

	lcp_row #(.DEPTH(MAX_P1_EVENTS)) u_row1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd1),
		.pos      (r_cl),
		.count    (n1),
		.rd_addr  (rd_addr1),
		.rd_stamp (rd1),
		.busy     (busy1)
	);

	lcp_row #(.DEPTH(MAX_P2_EVENTS)) u_row2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd2),
		.pos      (c_cl),
		.count    (n2),
		.rd_addr  (rd_addr2),
		.rd_stamp (rd2),
		.busy     (busy2)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: take an entry, wait for its rewrite, then output if the run ended.
	always_comb begin
		state_d     = state_q;
		entry.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				entry.ready = 1'b1;
				if (acc) begin
					state_d = ST_RIPPLE;
				end
			end
			ST_RIPPLE: begin
				if (!busy) begin
					state_d = end_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (emit_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration registers and matrix position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_events_q <= CFG_DATA_W'(5);
			p2_events_q <= CFG_DATA_W'(3);
			row_pos_q   <= '0;
			col_pos_q   <= '0;
			end_q       <= 1'b0;
		end else begin
			if (cfg_known) begin
				if (cfg.index == REG_P1_EVENTS) begin
					p1_events_q <= cfg.data;
				end else begin
					p2_events_q <= cfg.data;
				end
				row_pos_q <= '0;
				col_pos_q <= '0;
			end else if (acc) begin
				row_pos_q <= r_next;
				col_pos_q <= c_next;
			end
			if (acc) begin
				end_q <= end_run;
			end
		end
	end

	assign cfg.ready = 1'b1;

	// Output counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_pid_q <= 1'b0;
			emit_idx_q <= '0;
		end else if (restart) begin
			emit_pid_q <= 1'b0;
			emit_idx_q <= '0;
		end else if (load) begin
			if (at_end) begin
				emit_pid_q <= 1'b1;
				emit_idx_q <= '0;
			end else begin
				emit_idx_q <= emit_idx_q + 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_pid_q   <= emit_pid_q;
			out_idx_q   <= EVENT_IDX_W'(emit_idx_q);
			out_stamp_q <= emit_pid_q ? rd2 : rd1;
			out_last_q  <= at_end && emit_pid_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.process_id  = out_pid_q;
	assign result.event_index = out_idx_q;
	assign result.timestamp   = out_stamp_q;
	assign result.last_result = out_last_q;

	// No rewrite may still be travelling when a new entry is taken.
	`ASSERT_IMPLIES(a_idle_on_accept, acc, !busy)
	// An accepted entry always starts its rewrite phase.
	`ASSERT_NEXT(a_accept_to_ripple, acc, state_q == ST_RIPPLE)
	// The final result of a run belongs to process two.
	`ASSERT_IMPLIES(a_last_is_p2, result.valid && result.last_result, result.process_id)
	// The output counter stays inside the active process.
	`ASSERT_IMPLIES(a_emit_in_range, state_q == ST_EMIT, NW'(emit_idx_q) < emit_n)

endmodule

>>> test/lcp_stamp_checker.sv
// Watches the entry, result and configuration channels of the Lamport clock
// block, keeps its own copy of both timestamp tables and checks every result
// item against the oldest timestamp still due.
module lcp_stamp_checker (
	input  logic clk,
	input  logic arst_n,
	lcp_in_if    entry,
	lcp_out_if   result,
	lcp_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	import lcp_pkg::*;

	localparam int EVENTS_MAX = 16;
	localparam logic [CFG_DATA_W-1:0] P1_EVENTS_RESET = 5'd5;
	localparam logic [CFG_DATA_W-1:0] P2_EVENTS_RESET = 5'd3;
	localparam int PROC_ONE = 0;
	localparam int PROC_TWO = 1;

	typedef struct packed {
		logic                   proc;
		logic [EVENT_IDX_W-1:0] idx;
		stamp_t                 stamp;
		logic                   last;
	} stamp_item_t;

	// Timestamp tables, one row per process, and the matrix position.
	stamp_t                stamps [2][EVENTS_MAX];
	logic [CFG_DATA_W-1:0] events_reg [2];
	int unsigned           row_at;
	int unsigned           col_at;
	stamp_item_t           stamps_due [$];

	// Adds one and clips at the top of the stamp range.
	function automatic stamp_t plus_one(stamp_t s);
		logic [STAMP_W:0] sum;
		sum = {1'b0, s} + 1'b1;
		return (sum > STAMP_MAX) ? stamp_t'(STAMP_MAX) : sum[STAMP_W-1:0];
	endfunction

	// A count of zero acts as one; counts above the table size are clipped.
	function automatic int unsigned events_used(logic [CFG_DATA_W-1:0] v);
		if (v == '0)
			return 1;
		return (v > EVENTS_MAX) ? EVENTS_MAX : v;
	endfunction

	task automatic clear_stamps();
		for (int i = 0; i < EVENTS_MAX; i++) begin
			stamps[PROC_ONE][i] = stamp_t'(i + 1);
			stamps[PROC_TWO][i] = stamp_t'(i + 1);
		end
		row_at = 0;
		col_at = 0;
	endtask

	// Receiving event takes the larger of itself and the sender plus one, then
	// every later event of that process follows its predecessor by one.
	task automatic raise_stamp(int proc, int unsigned at, stamp_t sender, int unsigned count);
		stamp_t cand;
		cand = plus_one(sender);
		if (cand > stamps[proc][at])
			stamps[proc][at] = cand;
		for (int unsigned k = at + 1; k < count; k++)
			stamps[proc][k] = plus_one(stamps[proc][k-1]);
	endtask

	task automatic take_entry(relation_t rel);
		int unsigned n1;
		int unsigned n2;
		int unsigned r;
		int unsigned c;
		n1 = events_used(events_reg[PROC_ONE]);
		n2 = events_used(events_reg[PROC_TWO]);
		r = (row_at < n1) ? row_at : n1 - 1;
		c = (col_at < n2) ? col_at : n2 - 1;
		if (rel == REL_P1_TO_P2)
			raise_stamp(PROC_TWO, c, stamps[PROC_ONE][r], n2);
		else if (rel == REL_P2_TO_P1)
			raise_stamp(PROC_ONE, r, stamps[PROC_TWO][c], n1);

		// Step through the matrix in row-major order.
		c++;
		if (c >= n2) begin
			c = 0;
			r++;
		end
		row_at = r;
		col_at = c;

		// The final entry releases both tables and starts a new run.
		if (r >= n1) begin
			for (int unsigned i = 0; i < n1; i++)
				stamps_due.push_back('{1'b0, EVENT_IDX_W'(i), stamps[PROC_ONE][i], 1'b0});
			for (int unsigned i = 0; i < n2; i++)
				stamps_due.push_back('{1'b1, EVENT_IDX_W'(i), stamps[PROC_TWO][i],
					i + 1 == n2});
			clear_stamps();
		end
	endtask

	task automatic check_result();
		stamp_item_t want;
		if (stamps_due.size() == 0) begin
			$error("result item with no timestamp due: process_id %0d event_index %0d",
				result.process_id, result.event_index);
			fail_count++;
		end else begin
			want = stamps_due.pop_front();
			if (result.process_id !== want.proc) begin
				$error("process_id: expected %0d, got %0d", want.proc, result.process_id);
				fail_count++;
			end
			if (result.event_index !== want.idx) begin
				$error("event_index: expected %0d, got %0d", want.idx, result.event_index);
				fail_count++;
			end
			if (result.timestamp !== want.stamp) begin
				$error("timestamp: expected %0d, got %0d", want.stamp, result.timestamp);
				fail_count++;
			end
			if (result.last_result !== want.last) begin
				$error("last_result: expected %0d, got %0d", want.last, result.last_result);
				fail_count++;
			end
		end
	endtask

	// Handshakes are sampled at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			events_reg[PROC_ONE] = P1_EVENTS_RESET;
			events_reg[PROC_TWO] = P2_EVENTS_RESET;
			clear_stamps();
			stamps_due.delete();
			fail_count = 0;
		end else begin
			// A write to a known register restarts the run; others are ignored.
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_P1_EVENTS) begin
					events_reg[PROC_ONE] = cfg.data;
					clear_stamps();
				end else if (cfg.index == REG_P2_EVENTS) begin
					events_reg[PROC_TWO] = cfg.data;
					clear_stamps();
				end
			end
			if (entry.valid && entry.ready)
				take_entry(entry.relation);
			if (result.valid && result.ready)
				check_result();
		end
		pending = stamps_due.size();
	end

endmodule

>>> test/tb_lamport_clock_two_process.sv
// Drives matrix entries and register writes into the Lamport clock block,
// pulls its result items with a randomly stalling receiver and reports the
// verdict from the checker's failure and pending counts.
module tb_lamport_clock_two_process;
	import lcp_pkg::*;

	localparam relation_t REL_NONE = 2'sb00;
	localparam relation_t REL_ODD  = 2'sb10;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int EVENTS_MAX    = 16;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 2000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int snd_idle_pct = 17;
	int rcv_idle_pct = 83;
	int hold_reqs    = 0;
	int entries_sent = 0;
	int chk_fails;
	int chk_pending;

	lcp_in_if  entry_bus ();
	lcp_out_if stamp_bus ();
	lcp_cfg_if cfg_bus ();

	lamport_clock_two_process dut (
		.clk    (clk),
		.arst_n (arst_n),
		.entry  (entry_bus),
		.result (stamp_bus),
		.cfg    (cfg_bus)
	);

	lcp_stamp_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry      (entry_bus),
		.result     (stamp_bus),
		.cfg        (cfg_bus),
		.fail_count (chk_fails),
		.pending    (chk_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		stamp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stamp_bus.ready <= 1'b0;
			end else begin
				stamp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Ends the run if no item moves on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (entry_bus.valid && entry_bus.ready)
					|| (stamp_bus.valid && stamp_bus.ready)
					|| (cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int unsigned events_used(logic [CFG_DATA_W-1:0] v);
		if (v == '0)
			return 1;
		return (v > EVENTS_MAX) ? EVENTS_MAX : v;
	endfunction

	// Offers one matrix entry, with random gaps, and waits for it to be taken.
	task automatic send_entry(relation_t rel);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			entry_bus.valid <= 1'b0;
			@(negedge clk);
		end
		entry_bus.valid    <= 1'b1;
		entry_bus.relation <= rel;
		@(posedge clk);
		while (!entry_bus.ready)
			@(posedge clk);
		entries_sent++;
	endtask

	// Stops offering entries until every due result has arrived and the block
	// has had time to finish any rewrite still in progress.
	task automatic drain();
		@(negedge clk);
		entry_bus.valid <= 1'b0;
		while (chk_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Sets both event counts, then sends whole matrices of random entries.
	task automatic run_matrices(logic [CFG_DATA_W-1:0] p1, logic [CFG_DATA_W-1:0] p2,
			int runs, bit stall_out);
		int unsigned total;
		relation_t   rel;
		write_reg(REG_P1_EVENTS, p1);
		write_reg(REG_P2_EVENTS, p2);
		if (stall_out)
			hold_reqs++;
		total = events_used(p1) * events_used(p2) * runs;
		repeat (total) begin
			case ($urandom_range(9))
				0, 1, 2: rel = REL_P1_TO_P2;
				3, 4, 5: rel = REL_P2_TO_P1;
				9:       rel = REL_ODD;
				default: rel = REL_NONE;
			endcase
			send_entry(rel);
		end
	endtask

	initial begin : stimulus
		relation_t opening [15];
		opening = '{REL_P1_TO_P2, REL_P2_TO_P1, REL_NONE, REL_ODD, REL_P1_TO_P2,
			REL_P1_TO_P2, REL_P2_TO_P1, REL_P2_TO_P1, REL_NONE, REL_P1_TO_P2,
			REL_ODD, REL_P2_TO_P1, REL_P1_TO_P2, REL_NONE, REL_P2_TO_P1};
		entry_bus.valid    = 1'b0;
		entry_bus.relation = REL_NONE;
		cfg_bus.valid      = 1'b0;
		cfg_bus.index      = REG_P1_EVENTS;
		cfg_bus.data       = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Reset counts (five by three), every relation code including the
		// unused pattern.
		foreach (opening[i])
			send_entry(opening[i]);

		// Counts of zero behave as a single event each.
		write_reg(REG_P1_EVENTS, 5'd0);
		write_reg(REG_P2_EVENTS, 5'd0);
		send_entry(REL_P2_TO_P1);

		// A known register written mid-run restarts the matrix.
		write_reg(REG_P1_EVENTS, 5'd2);
		write_reg(REG_P2_EVENTS, 5'd2);
		send_entry(REL_P1_TO_P2);
		send_entry(REL_P2_TO_P1);
		write_reg(REG_P2_EVENTS, 5'd2);
		send_entry(REL_P2_TO_P1);
		send_entry(REL_P1_TO_P2);

		// Unknown indexes mid-run must leave the run untouched.
		write_reg(REG_SPARE_A, 5'd1);
		write_reg(REG_SPARE_B, 5'd31);
		send_entry(REL_ODD);
		send_entry(REL_P1_TO_P2);

		// Sender mostly busy, receiver mostly stalled.
		run_matrices(5'd31, 5'd1, 1, 1'b0);
		drain();
		while (entries_sent < 85)
			run_matrices(5'($urandom_range(6)), 5'($urandom_range(6)),
				1 + $urandom_range(2), 1'b0);

		// Sender mostly idle, receiver mostly ready.
		snd_idle_pct = 83;
		rcv_idle_pct = 17;
		run_matrices(5'd1, 5'd31, 1, 1'b0);
		while (entries_sent < 150)
			run_matrices(5'($urandom_range(6)), 5'($urandom_range(6)),
				1 + $urandom_range(2), 1'b0);

		// No idling: the full-size matrix, then a long receiver hold-off while
		// entries keep coming so the input backs up.
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		run_matrices(5'd16, 5'd16, 1, 1'b0);
		run_matrices(5'd2, 5'd2, 2, 1'b1);

		drain();
		if (chk_fails == 0 && chk_pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
